### rtl/host_command_packet_word_packer_defines.svh
// assertion macros shared by the host command packet word packer modules
`ifndef HOST_COMMAND_PACKET_WORD_PACKER_DEFINES_SVH
`define HOST_COMMAND_PACKET_WORD_PACKER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define HCPWP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define HCPWP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hcpwp_pkg.sv
// package: shared types, codes and constants of the host command packet word packer
`timescale 1ns / 1ps

package hcpwp_pkg;

    // packet buffer
    localparam int MAX_PACKET = 252;
    localparam int STORE_AW   = $clog2(MAX_PACKET);

    // host command bytes
    localparam logic [7:0] CMD_BYTE_DATA = 8'h00;
    localparam logic [7:0] CMD_BYTE_FREQ = 8'h01;

    // result kinds
    localparam logic [1:0] KIND_BITS = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;
    localparam logic [1:0] KIND_FREQ = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_START_MARKER  = 2'd0;
    localparam logic [1:0] CFG_HEADER_BYTES  = 2'd1;
    localparam logic [1:0] CFG_TRAILER_BYTES = 2'd2;

    // configuration reset values
    localparam logic [7:0] RST_START_MARKER  = 8'd170;
    localparam logic [3:0] RST_HEADER_BYTES  = 4'd2;
    localparam logic [3:0] RST_TRAILER_BYTES = 4'd2;

    typedef enum logic [1:0] {
        CMD_READ,
        CMD_LEN,
        CMD_DATA,
        CMD_FREQ
    } cmd_phase_t;

    typedef enum logic [1:0] {
        FR_WAIT,
        FR_HEAD,
        FR_LEN,
        FR_BODY
    } frame_phase_t;

    typedef enum logic [1:0] {
        SEQ_RUN,
        SEQ_ADDR,
        SEQ_DATA,
        SEQ_PUSH
    } seq_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;   // input word taken this cycle
        logic rd_en;    // read packet buffer at the read index
        logic capture;  // buffer byte is on the read data, pack it
        logic push;     // move the packed word to the output register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pkt_done;   // accepted byte completes a packet
        logic out_valid;  // output register holds a word
        logic word_full;  // byte being captured fills the word or ends the packet
        logic pend_last;  // packed word is the last of the packet
    } dp_status_t;

endpackage

### rtl/hcpwp_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module hcpwp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/hcpwp_ctrl.sv
// controller: input handshake and packet read-back sequencer
`timescale 1ns / 1ps
`include "host_command_packet_word_packer_defines.svh"

module hcpwp_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   m_tready,
    input  hcpwp_pkg::dp_status_t  status,
    output hcpwp_pkg::ctrl_cmd_t   cmd
);

    hcpwp_pkg::seq_state_t state_reg;
    hcpwp_pkg::seq_state_t state_next;
    logic                  slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hcpwp_pkg::SEQ_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        slot_free  = !status.out_valid || m_tready;
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            hcpwp_pkg::SEQ_RUN: begin
                s_tready   = slot_free;
                cmd.accept = s_tvalid && slot_free;
                if (status.pkt_done) begin
                    state_next = hcpwp_pkg::SEQ_ADDR;
                end
            end
            hcpwp_pkg::SEQ_ADDR: begin
                cmd.rd_en  = 1'b1;
                state_next = hcpwp_pkg::SEQ_DATA;
            end
            hcpwp_pkg::SEQ_DATA: begin
                cmd.capture = 1'b1;
                state_next  = status.word_full ? hcpwp_pkg::SEQ_PUSH : hcpwp_pkg::SEQ_ADDR;
            end
            hcpwp_pkg::SEQ_PUSH: begin
                if (slot_free) begin
                    cmd.push   = 1'b1;
                    state_next = status.pend_last ? hcpwp_pkg::SEQ_RUN : hcpwp_pkg::SEQ_ADDR;
                end
            end
            default: begin
                state_next = hcpwp_pkg::SEQ_RUN;
            end
        endcase
    end

    `HCPWP_ASSERT_NXT(a_done_starts_readback, aclk, aresetn, cmd.accept && status.pkt_done, state_reg == hcpwp_pkg::SEQ_ADDR, "completed packet did not start read-back")
    `HCPWP_ASSERT_IMP(a_data_after_addr, aclk, aresetn, state_reg == hcpwp_pkg::SEQ_DATA, $past(state_reg) == hcpwp_pkg::SEQ_ADDR, "buffer capture without a read issued")

endmodule

### rtl/hcpwp_dp.sv
// datapath: command parser, packet framer, packet buffer, word packer and output register
`timescale 1ns / 1ps
`include "host_command_packet_word_packer_defines.svh"

module hcpwp_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [7:0]            s_tdata,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    input  hcpwp_pkg::ctrl_cmd_t  cmd,
    output hcpwp_pkg::dp_status_t status,
    output logic                  m_tvalid,
    output logic [1:0]            m_tuser,
    output logic [31:0]           m_tdata,
    output logic                  m_tlast
);

    // configuration
    logic [7:0] start_marker_reg, start_marker_next;
    logic [3:0] header_bytes_reg, header_bytes_next;
    logic [3:0] trailer_bytes_reg, trailer_bytes_next;

    // command parser
    hcpwp_pkg::cmd_phase_t cmd_phase_reg, cmd_phase_next;
    logic        count_idx_reg, count_idx_next;
    logic [15:0] host_count_reg, host_count_next;
    logic [15:0] host_seen_reg, host_seen_next;
    logic [31:0] freq_reg, freq_next;
    logic [1:0]  freq_idx_reg, freq_idx_next;

    // framer
    hcpwp_pkg::frame_phase_t frame_phase_reg, frame_phase_next;
    logic [7:0] frame_pos_reg, frame_pos_next;
    logic [8:0] frame_len_reg, frame_len_next;

    // read-back and packing
    logic [7:0]  emit_len_reg, emit_len_next;
    logic [7:0]  rd_idx_reg, rd_idx_next;
    logic [1:0]  lane_reg, lane_next;
    logic [31:0] word_reg, word_next;
    logic        pend_last_reg, pend_last_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [31:0] out_value_reg, out_value_next;
    logic        out_last_reg, out_last_next;

    logic [3:0]  eff_hdr;
    logic [7:0]  pos_inc;
    logic [8:0]  len_calc;
    logic [7:0]  done_len;
    logic        pkt_done;
    logic        freq_done;
    logic        store_en;
    logic [7:0]  store_addr;
    logic        byte_last;
    logic [7:0]  rd_data;

    hcpwp_ram #(
        .WIDTH (8),
        .DEPTH (hcpwp_pkg::MAX_PACKET)
    ) u_store (
        .clk   (aclk),
        .we    (store_en),
        .waddr (store_addr[hcpwp_pkg::STORE_AW-1:0]),
        .wdata (s_tdata),
        .re    (cmd.rd_en),
        .raddr (rd_idx_reg[hcpwp_pkg::STORE_AW-1:0]),
        .rdata (rd_data)
    );

    always_comb begin
        // a header below two bytes means the length byte follows the marker
        eff_hdr   = (header_bytes_reg < 4'd2) ? 4'd1 : header_bytes_reg;
        pos_inc   = frame_pos_reg + 8'd1;
        len_calc  = 9'(eff_hdr) + 9'd1 + 9'(s_tdata) + 9'(trailer_bytes_reg);
        byte_last = (rd_idx_reg + 8'd1) == emit_len_reg;

        start_marker_next  = start_marker_reg;
        header_bytes_next  = header_bytes_reg;
        trailer_bytes_next = trailer_bytes_reg;
        cmd_phase_next     = cmd_phase_reg;
        count_idx_next     = count_idx_reg;
        host_count_next    = host_count_reg;
        host_seen_next     = host_seen_reg;
        freq_next          = freq_reg;
        freq_idx_next      = freq_idx_reg;
        frame_phase_next   = frame_phase_reg;
        frame_pos_next     = frame_pos_reg;
        frame_len_next     = frame_len_reg;
        emit_len_next      = emit_len_reg;
        rd_idx_next        = rd_idx_reg;
        lane_next          = lane_reg;
        word_next          = word_reg;
        pend_last_next     = pend_last_reg;
        out_valid_next     = out_valid_reg;
        out_kind_next      = out_kind_reg;
        out_value_next     = out_value_reg;
        out_last_next      = out_last_reg;
        done_len           = frame_len_reg[7:0];
        pkt_done           = 1'b0;
        freq_done          = 1'b0;
        store_en           = 1'b0;
        store_addr         = frame_pos_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                hcpwp_pkg::CFG_START_MARKER:  start_marker_next  = cfg_data;
                hcpwp_pkg::CFG_HEADER_BYTES:  header_bytes_next  = cfg_data[3:0];
                hcpwp_pkg::CFG_TRAILER_BYTES: trailer_bytes_next = cfg_data[3:0];
                default: ;
            endcase
        end

        if (cmd.accept) begin
            unique case (cmd_phase_reg)
                hcpwp_pkg::CMD_READ: begin
                    if (s_tdata == hcpwp_pkg::CMD_BYTE_DATA) begin
                        cmd_phase_next  = hcpwp_pkg::CMD_LEN;
                        host_count_next = '0;
                        host_seen_next  = '0;
                        count_idx_next  = 1'b0;
                    end else if (s_tdata == hcpwp_pkg::CMD_BYTE_FREQ) begin
                        cmd_phase_next = hcpwp_pkg::CMD_FREQ;
                        freq_idx_next  = '0;
                    end
                end
                hcpwp_pkg::CMD_LEN: begin
                    host_count_next = {host_count_reg[7:0], s_tdata};
                    if (!count_idx_reg) begin
                        count_idx_next = 1'b1;
                    end else begin
                        count_idx_next = 1'b0;
                        cmd_phase_next = (host_count_next == 16'd0) ? hcpwp_pkg::CMD_READ
                                                                    : hcpwp_pkg::CMD_DATA;
                    end
                end
                hcpwp_pkg::CMD_DATA: begin
                    unique case (frame_phase_reg)
                        hcpwp_pkg::FR_WAIT: begin
                            if (s_tdata == start_marker_reg) begin
                                store_en         = 1'b1;
                                store_addr       = '0;
                                frame_pos_next   = 8'd1;
                                frame_len_next   = '0;
                                frame_phase_next = (eff_hdr <= 4'd1) ? hcpwp_pkg::FR_LEN
                                                                     : hcpwp_pkg::FR_HEAD;
                            end
                        end
                        hcpwp_pkg::FR_HEAD: begin
                            store_en       = frame_pos_reg < 8'(hcpwp_pkg::MAX_PACKET);
                            frame_pos_next = pos_inc;
                            if (pos_inc >= 8'(eff_hdr)) begin
                                frame_phase_next = hcpwp_pkg::FR_LEN;
                            end
                        end
                        hcpwp_pkg::FR_LEN: begin
                            store_en       = frame_pos_reg < 8'(hcpwp_pkg::MAX_PACKET);
                            frame_pos_next = pos_inc;
                            if (len_calc > 9'(hcpwp_pkg::MAX_PACKET)) begin
                                // oversize: drop and hunt for a new marker
                                frame_phase_next = hcpwp_pkg::FR_WAIT;
                                frame_pos_next   = '0;
                                frame_len_next   = '0;
                            end else if (9'(pos_inc) >= len_calc) begin
                                // empty body and no trailer
                                pkt_done         = 1'b1;
                                done_len         = len_calc[7:0];
                                frame_phase_next = hcpwp_pkg::FR_WAIT;
                                frame_pos_next   = '0;
                                frame_len_next   = '0;
                            end else begin
                                frame_phase_next = hcpwp_pkg::FR_BODY;
                                frame_len_next   = len_calc;
                            end
                        end
                        hcpwp_pkg::FR_BODY: begin
                            store_en       = frame_pos_reg < 8'(hcpwp_pkg::MAX_PACKET);
                            frame_pos_next = pos_inc;
                            if (9'(pos_inc) >= frame_len_reg) begin
                                pkt_done         = 1'b1;
                                done_len         = frame_len_reg[7:0];
                                frame_phase_next = hcpwp_pkg::FR_WAIT;
                                frame_pos_next   = '0;
                                frame_len_next   = '0;
                            end
                        end
                        default: ;
                    endcase
                    host_seen_next = host_seen_reg + 16'd1;
                    if (host_seen_next >= host_count_reg) begin
                        cmd_phase_next = hcpwp_pkg::CMD_READ;
                    end
                end
                hcpwp_pkg::CMD_FREQ: begin
                    freq_next     = {freq_reg[23:0], s_tdata};
                    freq_idx_next = freq_idx_reg + 2'd1;
                    if (freq_idx_next == 2'd0) begin
                        freq_done      = 1'b1;
                        cmd_phase_next = hcpwp_pkg::CMD_READ;
                    end
                end
                default: ;
            endcase
        end

        // read-back: packet bytes fill lanes from the top byte down
        if (pkt_done) begin
            emit_len_next = done_len;
            rd_idx_next   = '0;
            lane_next     = '0;
            word_next     = '0;
        end
        if (cmd.capture) begin
            word_next      = word_reg | (32'(rd_data) << {~lane_reg, 3'b000});
            lane_next      = lane_reg + 2'd1;
            rd_idx_next    = rd_idx_reg + 8'd1;
            pend_last_next = byte_last;
        end
        if (cmd.push) begin
            word_next = '0;
            lane_next = '0;
        end

        if (pkt_done) begin
            out_valid_next = 1'b1;
            out_kind_next  = hcpwp_pkg::KIND_BITS;
            out_value_next = (32'(done_len) << 3) - 32'd1;
            out_last_next  = 1'b0;
        end else if (freq_done) begin
            out_valid_next = 1'b1;
            out_kind_next  = hcpwp_pkg::KIND_FREQ;
            out_value_next = freq_next;
            out_last_next  = 1'b1;
        end else if (cmd.push) begin
            out_valid_next = 1'b1;
            out_kind_next  = hcpwp_pkg::KIND_WORD;
            out_value_next = word_reg;
            out_last_next  = pend_last_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_marker_reg  <= hcpwp_pkg::RST_START_MARKER;
            header_bytes_reg  <= hcpwp_pkg::RST_HEADER_BYTES;
            trailer_bytes_reg <= hcpwp_pkg::RST_TRAILER_BYTES;
            cmd_phase_reg     <= hcpwp_pkg::CMD_READ;
            count_idx_reg     <= 1'b0;
            host_count_reg    <= '0;
            host_seen_reg     <= '0;
            freq_idx_reg      <= '0;
            frame_phase_reg   <= hcpwp_pkg::FR_WAIT;
            frame_pos_reg     <= '0;
            frame_len_reg     <= '0;
            emit_len_reg      <= '0;
            rd_idx_reg        <= '0;
            lane_reg          <= '0;
            pend_last_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            start_marker_reg  <= start_marker_next;
            header_bytes_reg  <= header_bytes_next;
            trailer_bytes_reg <= trailer_bytes_next;
            cmd_phase_reg     <= cmd_phase_next;
            count_idx_reg     <= count_idx_next;
            host_count_reg    <= host_count_next;
            host_seen_reg     <= host_seen_next;
            freq_idx_reg      <= freq_idx_next;
            frame_phase_reg   <= frame_phase_next;
            frame_pos_reg     <= frame_pos_next;
            frame_len_reg     <= frame_len_next;
            emit_len_reg      <= emit_len_next;
            rd_idx_reg        <= rd_idx_next;
            lane_reg          <= lane_next;
            pend_last_reg     <= pend_last_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        freq_reg      <= freq_next;
        word_reg      <= word_next;
        out_kind_reg  <= out_kind_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    assign status.pkt_done  = pkt_done;
    assign status.out_valid = out_valid_reg;
    assign status.word_full = (lane_reg == 2'd3) || byte_last;
    assign status.pend_last = pend_last_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = out_value_reg;
    assign m_tlast  = out_last_reg;

    `HCPWP_ASSERT_IMP(a_rd_within_len, aclk, aresetn, 1'b1, rd_idx_reg <= emit_len_reg, "read index ran past the packet length")
    `HCPWP_ASSERT_NXT(a_bits_word_first, aclk, aresetn, pkt_done, out_valid_reg && out_kind_reg == hcpwp_pkg::KIND_BITS, "bit count word not loaded on packet completion")

endmodule

### rtl/host_command_packet_word_packer.sv
// top level: host command packet word packer
`timescale 1ns / 1ps

// Host command bytes enter on the s_ stream, one byte per word, and results
// leave on the m_ stream. Command byte 0x00 takes a 16-bit big-endian count and
// passes that many following bytes to the packet framer; command byte 0x01 takes
// a 32-bit big-endian frequency and emits it as one request word (tuser 2, tlast
// set); any other command byte is ignored. The framer hunts for the start marker,
// gathers header, length byte, payload and trailer into a 252 x 8 packet buffer,
// and drops packets that would not fit. A finished packet gives first its bit
// count minus one (tuser 0), then the packet as big-endian 32-bit words (tuser 1),
// the final word left-aligned, zero-padded and marked with tlast. Bytes are taken
// at one per cycle while the output register is empty or its word leaves in the
// same cycle; s_tready is low while a result word waits on m_tready and while a
// finished packet is read back. Read-back goes through the single read port of
// the packet buffer: each byte takes a read state and a capture state, and each
// word a push state that waits until the output register is free.
// The buffer needs no clearing pass after reset. Configuration writes (index 0
// start marker, 1 header bytes, 2 trailer bytes, other indexes ignored) are
// always taken and belong in idle periods.

module host_command_packet_word_packer (
    input  logic        aclk,
    input  logic        aresetn,

    // host byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] value
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast,    // final word of a packet, or a frequency request

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    hcpwp_pkg::ctrl_cmd_t  cmd;     // sequencer commands
    hcpwp_pkg::dp_status_t status;  // framer and packer status

    // register writes are never back-pressured
    assign cfg_ready = 1'b1;

    // input handshake and read-back sequencing
    hcpwp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // parser, framer, packet buffer and output register
    hcpwp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

### bench/tb_host_command_packet_word_packer.sv
// testbench: host command packet word packer against a behavioural predictor
`timescale 1ns / 1ps

module tb_host_command_packet_word_packer;

    import hcpwp_pkg::*;

    localparam int STALL_LIMIT   = 3000;  // cycles with no word moving on any channel
    localparam int SETTLE_CYCLES = 16;    // quiet time before a register write or the end
    localparam logic [1:0] CFG_SPARE = 2'd3;  // index with no register behind it

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] value;
        logic        last;
    } packer_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [31:0] value
    logic [1:0]  m_tuser;     // [1:0] kind
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    host_command_packet_word_packer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // host bytes still to be driven, and result words the block still owes us
    logic [7:0]     host_bytes_q[$];
    packer_result_t result_words_due[$];
    logic [7:0]     packet_bytes[$];   // scratch for building one packet

    logic no_idle;   // both sides run flat out while set

    int mismatch_count = 0;
    int words_checked  = 0;
    int bytes_taken    = 0;
    int packets_framed = 0;
    int freq_requests  = 0;
    int quiet_cycles   = 0;

    // ---------------------------------------------------------------
    // predictor: mirror of the registers and of the parser/framer state
    // ---------------------------------------------------------------
    logic [7:0]   marker;
    logic [3:0]   hdr;
    logic [3:0]   trl;

    cmd_phase_t   cmd_ph;
    logic         count_idx;
    logic [15:0]  host_cnt;
    logic [15:0]  host_seen;
    logic [31:0]  freq_acc;
    logic [1:0]   freq_idx;
    frame_phase_t fr_ph;
    logic [7:0]   fr_pos;
    logic [8:0]   fr_len;
    logic [7:0]   fr_buf [MAX_PACKET];

    // header length as the framer sees it: anything under two means marker only
    function automatic int eff_header();
        return (hdr < 2) ? 1 : int'(hdr);
    endfunction

    function automatic int largest_payload();
        return MAX_PACKET - eff_header() - 1 - int'(trl);
    endfunction

    task automatic put_due(input logic [1:0] k, input logic [31:0] v, input logic l);
        packer_result_t r;
        r.kind  = k;
        r.value = v;
        r.last  = l;
        result_words_due.push_back(r);
    endtask

    task automatic keep_byte(input logic [7:0] b);
        if (fr_pos < MAX_PACKET) fr_buf[fr_pos] = b;
        fr_pos = fr_pos + 8'd1;
    endtask

    // bit count first, then the packet as big-endian words, tail left-aligned
    task automatic emit_packet_words();
        logic [31:0] word;
        int          shift;
        int          i;
        put_due(KIND_BITS, 32'(fr_len) * 32'd8 - 32'd1, 1'b0);
        word  = '0;
        shift = 24;
        for (i = 0; i < fr_len && i < MAX_PACKET; i++) begin
            word |= 32'(fr_buf[i]) << shift;
            if (shift == 0) begin
                put_due(KIND_WORD, word, (i + 1 == fr_len));
                word  = '0;
                shift = 24;
            end else begin
                shift -= 8;
            end
        end
        if (shift != 24) put_due(KIND_WORD, word, 1'b1);
        packets_framed++;
    endtask

    task automatic frame_host_byte(input logic [7:0] b);
        int eh;
        int total;
        bit may_finish;
        eh         = eff_header();
        may_finish = 1'b0;
        case (fr_ph)
            FR_WAIT: begin
                if (b == marker) begin
                    fr_pos = '0;
                    fr_len = '0;
                    keep_byte(b);
                    fr_ph = (eh <= 1) ? FR_LEN : FR_HEAD;
                end
            end
            FR_HEAD: begin
                keep_byte(b);
                if (fr_pos >= eh) fr_ph = FR_LEN;
            end
            FR_LEN: begin
                keep_byte(b);
                total = eh + 1 + int'(b) + int'(trl);
                if (total > MAX_PACKET) begin
                    // oversize: drop and hunt for the next marker
                    fr_ph  = FR_WAIT;
                    fr_pos = '0;
                    fr_len = '0;
                end else begin
                    fr_len     = total[8:0];
                    fr_ph      = FR_BODY;
                    may_finish = 1'b1;
                end
            end
            default: begin
                keep_byte(b);
                may_finish = 1'b1;
            end
        endcase
        if (may_finish && fr_pos >= fr_len) begin
            emit_packet_words();
            fr_ph  = FR_WAIT;
            fr_pos = '0;
            fr_len = '0;
        end
    endtask

    task automatic parse_host_byte(input logic [7:0] b);
        case (cmd_ph)
            CMD_READ: begin
                if (b == CMD_BYTE_DATA) begin
                    cmd_ph    = CMD_LEN;
                    host_cnt  = '0;
                    host_seen = '0;
                    count_idx = 1'b0;
                end else if (b == CMD_BYTE_FREQ) begin
                    cmd_ph   = CMD_FREQ;
                    freq_idx = '0;
                end
            end
            CMD_LEN: begin
                host_cnt = {host_cnt[7:0], b};
                if (!count_idx) begin
                    count_idx = 1'b1;
                end else begin
                    count_idx = 1'b0;
                    cmd_ph    = (host_cnt == 0) ? CMD_READ : CMD_DATA;
                end
            end
            CMD_DATA: begin
                frame_host_byte(b);
                host_seen = host_seen + 16'd1;
                if (host_seen >= host_cnt) cmd_ph = CMD_READ;
            end
            default: begin
                freq_acc = {freq_acc[23:0], b};
                freq_idx = freq_idx + 2'd1;
                if (freq_idx == 0) begin
                    put_due(KIND_FREQ, freq_acc, 1'b1);
                    freq_requests++;
                    cmd_ph = CMD_READ;
                end
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // stimulus builders, run without advancing time; then waits and register writes
    // ---------------------------------------------------------------
    function automatic logic [7:0] noise_byte();
        logic [7:0] r;
        do r = 8'($urandom_range(255)); while (r == marker);
        return r;
    endfunction

    task automatic queue_freq(input logic [31:0] f);
        host_bytes_q.push_back(CMD_BYTE_FREQ);
        host_bytes_q.push_back(f[31:24]);
        host_bytes_q.push_back(f[23:16]);
        host_bytes_q.push_back(f[15:8]);
        host_bytes_q.push_back(f[7:0]);
    endtask

    // data command, big-endian count, then that many bytes of the scratch packet
    task automatic queue_run(input int first, input int cnt);
        logic [15:0] c;
        int          i;
        c = cnt[15:0];
        host_bytes_q.push_back(CMD_BYTE_DATA);
        host_bytes_q.push_back(c[15:8]);
        host_bytes_q.push_back(c[7:0]);
        for (i = first; i < first + cnt; i++) host_bytes_q.push_back(packet_bytes[i]);
    endtask

    // one packet for the current settings; optionally with junk in front, split
    // over two data runs with another command between, or left unfinished
    task automatic queue_packet(input int pay_len, input bit lead, input bit split,
                                input bit abandon);
        int n;
        int cut;
        packet_bytes.delete();
        if (lead) repeat ($urandom_range(3, 1)) packet_bytes.push_back(noise_byte());
        packet_bytes.push_back(marker);
        repeat (eff_header() - 1) packet_bytes.push_back(8'($urandom_range(255)));
        packet_bytes.push_back(pay_len[7:0]);
        if (pay_len > largest_payload()) begin
            // dropped packet, a little junk after the length byte
            repeat ($urandom_range(4)) packet_bytes.push_back(noise_byte());
        end else begin
            repeat (pay_len + int'(trl)) packet_bytes.push_back(8'($urandom_range(255)));
        end
        n = packet_bytes.size();
        if (split) begin
            cut = $urandom_range(n - 1, 1);
            queue_run(0, cut);
            if ($urandom_range(1)) queue_freq($urandom());
            else host_bytes_q.push_back(8'($urandom_range(255, 2)));
            if (!abandon) queue_run(cut, n - cut);
        end else begin
            queue_run(0, n);
        end
    endtask

    // mostly well-formed packets with random content, the rest other commands and junk
    task automatic queue_traffic(input int budget);
        int start;
        int pick;
        int sel;
        int pay;
        start = host_bytes_q.size();
        while (host_bytes_q.size() - start < budget) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                sel = $urandom_range(19);
                if (sel == 0) pay = $urandom_range(255, largest_payload() + 1);
                else if (sel == 1) pay = $urandom_range(40, 13);
                else pay = $urandom_range(12);
                queue_packet(pay, $urandom_range(5) == 0, $urandom_range(4) == 0,
                             $urandom_range(24) == 0);
            end else if (pick < 70) begin
                queue_freq($urandom());
            end else if (pick < 80) begin
                host_bytes_q.push_back(8'($urandom_range(255, 2)));  // unknown command
            end else if (pick < 88) begin
                queue_run(0, 0);                                      // zero count
            end else begin
                packet_bytes.delete();
                repeat ($urandom_range(6, 1)) packet_bytes.push_back(8'($urandom_range(255)));
                queue_run(0, packet_bytes.size());
            end
        end
    endtask

    // sender empty and every owed word back, then a short quiet spell
    task automatic wait_all_words();
        while (host_bytes_q.size() != 0 || s_tvalid || result_words_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_START_MARKER:  marker = val;
            CFG_HEADER_BYTES:  hdr    = val[3:0];
            CFG_TRAILER_BYTES: trl    = val[3:0];
            default: ;
        endcase
    endtask

    // ---------------------------------------------------------------
    // driver: host bytes out of the queue, prediction on each accepted word
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_host_byte(s_tdata);
                bytes_taken++;
            end
            // bus free: offer the next byte unless this cycle idles
            if (!s_tvalid || s_tready) begin
                if (host_bytes_q.size() != 0 && (no_idle || $urandom_range(99) >= 6)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= host_bytes_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: every result word against the oldest owed word
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        packer_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (result_words_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: expected no word, got kind %0d value %h last %0b",
                             $time, m_tuser, m_tdata, m_tlast);
                end else begin
                    want = result_words_due.pop_front();
                    words_checked++;
                    if (m_tuser !== want.kind || m_tdata !== want.value ||
                        m_tlast !== want.last) begin
                        mismatch_count++;
                        $display("%0t: expected %0d %h %0b, got %0d %h %0b (kind value last)",
                                 $time, want.kind, want.value, want.last,
                                 m_tuser, m_tdata, m_tlast);
                    end
                end
            end
            m_tready <= no_idle || $urandom_range(99) >= 6;
        end
    end

    // watchdog: a long spell with no word moving anywhere means the block hung
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles, %0d words still owed",
                         $time, STALL_LIMIT, result_words_due.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // sequence of phases
    // ---------------------------------------------------------------
    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        no_idle   = 1'b0;

        // predictor starts from the reset state
        marker    = RST_START_MARKER;
        hdr       = RST_HEADER_BYTES;
        trl       = RST_TRAILER_BYTES;
        cmd_ph    = CMD_READ;
        count_idx = 1'b0;
        host_cnt  = '0;
        host_seen = '0;
        freq_acc  = '0;
        freq_idx  = '0;
        fr_ph     = FR_WAIT;
        fr_pos    = '0;
        fr_len    = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: frequency extremes, zero count, unknown command, small packet
        @(negedge aclk);
        queue_freq(32'hFFFF_FFFF);
        queue_freq(32'h0000_0000);
        queue_run(0, 0);
        host_bytes_q.push_back(8'hFF);
        queue_packet(1, 1'b0, 1'b0, 1'b0);
        wait_all_words();

        // marker 0x00, short header, no trailer; junk in the upper nibbles
        write_reg(CFG_START_MARKER, 8'h00);
        write_reg(CFG_HEADER_BYTES, 8'hA0);
        write_reg(CFG_TRAILER_BYTES, 8'h50);
        @(negedge aclk);
        queue_packet(0, 1'b0, 1'b0, 1'b0);   // empty packet, emitted on its length byte
        queue_traffic(20);
        wait_all_words();

        // widest header and trailer, marker 0xff; sender drains mid-phase
        write_reg(CFG_START_MARKER, 8'hFF);
        write_reg(CFG_HEADER_BYTES, 8'h0F);
        write_reg(CFG_TRAILER_BYTES, 8'hFF);
        write_reg(CFG_SPARE, 8'h5A);
        @(negedge aclk);
        queue_traffic(12);
        wait_all_words();
        queue_traffic(12);
        wait_all_words();

        // one byte over the buffer and a longer packet, both sides without idling
        write_reg(CFG_START_MARKER, 8'($urandom_range(255)));
        write_reg(CFG_HEADER_BYTES, 8'd1);
        write_reg(CFG_TRAILER_BYTES, 8'd8);
        @(negedge aclk);
        no_idle = 1'b1;
        queue_packet(largest_payload() + 1, 1'b0, 1'b0, 1'b0);
        queue_packet(24, 1'b0, 1'b0, 1'b0);
        queue_traffic(12);
        wait_all_words();
        no_idle = 1'b0;

        write_reg(CFG_START_MARKER, 8'($urandom_range(255)));
        write_reg(CFG_HEADER_BYTES, 8'd8);
        write_reg(CFG_TRAILER_BYTES, 8'd0);
        @(negedge aclk);
        queue_traffic(15);
        wait_all_words();

        $display("%0d host bytes sent, %0d packets and %0d frequency requests framed",
                 bytes_taken, packets_framed, freq_requests);
        $display("%0d result words checked over five register settings", words_checked);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### host_command_packet_word_packer.f
+incdir+rtl
rtl/hcpwp_pkg.sv
rtl/hcpwp_ram.sv
rtl/hcpwp_ctrl.sv
rtl/hcpwp_dp.sv
rtl/host_command_packet_word_packer.sv
bench/tb_host_command_packet_word_packer.sv
